/* rtl/preintegrated_transfer_table_macros.svh */
// assertion macros for the pre-integrated transfer table
// expects clk_i and rst_ni in the scope of each use
`ifndef PREINTEGRATED_TRANSFER_TABLE_MACROS_SVH
`define PREINTEGRATED_TRANSFER_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTT_ASSERT_IMP(lbl, ante, cons, msg)
`define PTT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/ptt_pkg.sv */
// shared types, constants and constant tables of the pre-integrated transfer table
// no dependencies
`default_nettype none
package ptt_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int IDX_W = 8;
  localparam int CH_W = 8;
  localparam int WORD_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_PLAIN,
    ST_TCALC,
    ST_LOG,
    ST_DIV,
    ST_EXP,
    ST_CORR,
    ST_BLEND,
    ST_FINAL
  } state_e;

  typedef logic [16:0] trans_tab_t [256];
  typedef logic [30:0] root_tab_t [17];

  // transmittance 1-a/255 in q1.16, rounded
  function automatic trans_tab_t calc_trans();
    trans_tab_t tab;
    for (int a = 0; a < 256; a++) begin
      tab[a] = 17'(((255 - a) * 65536 + 127) / 255);
    end
    return tab;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x = x_in;
    res = '0;
    for (int j = 31; j >= 0; j--) begin
      bitv = 64'd1 << (2 * j);
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // 2^(-2^-i) in q1.30
  function automatic root_tab_t calc_roots();
    root_tab_t r;
    logic [63:0] prev;
    r[0] = 31'h2000_0000;
    for (int i = 1; i <= 16; i++) begin
      prev = {33'd0, r[i-1]} << 30;
      r[i] = 31'(isqrt(prev));
    end
    return r;
  endfunction

  localparam trans_tab_t TRANS_TAB = calc_trans();
  localparam root_tab_t ROOTS = calc_roots();

  // floor(x/255) for x up to 255*255
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

/* rtl/ptt_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/preintegrated_transfer_table.sv */
// top level of the pre-integrated transfer table: sequencer, shared multiplier, datapath
// depends on ptt_pkg, ptt_ram and the assertion macro header
//
// channel   direction  handshake                     payload
// config    in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
// item      in         start, busy                   operation_i .. back_index_i
// result    out        out_valid_o (one cycle)       out_red_o .. out_transparency_o
//
// a load is written from the accepting cycle and leaves the block idle; a plain query
// passes the read, fetch and plain states; for a pre-integrated query, n = |front-back|, per
// entry the shared multiplier runs 16 log squarings, 16 exp products and 8 blend products,
// and a bit-serial divider runs between log and exp; an entry with opacity 0 or 255, or a
// segment of length one, skips log, divide, exp and correction and goes straight to blend
// the table has no reset; mode resets to plain; the receiver cannot stall results
`default_nettype none
module preintegrated_transfer_table
  import ptt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [1:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             operation_i,
  input  wire logic [IDX_W-1:0] load_index_i,
  input  wire logic [CH_W-1:0]  entry_red_i,
  input  wire logic [CH_W-1:0]  entry_green_i,
  input  wire logic [CH_W-1:0]  entry_blue_i,
  input  wire logic [CH_W-1:0]  entry_opacity_i,
  input  wire logic [IDX_W-1:0] front_index_i,
  input  wire logic [IDX_W-1:0] back_index_i,
  output logic                  out_valid_o,
  output logic      [CH_W-1:0]  out_red_o,
  output logic      [CH_W-1:0]  out_green_o,
  output logic      [CH_W-1:0]  out_blue_o,
  output logic      [CH_W-1:0]  out_transparency_o
);

  `include "preintegrated_transfer_table_macros.svh"

  localparam int AW = $clog2(TABLE_ENTRIES);

  state_e state_q, state_d;
  logic mode_q;
  logic valid_q, valid_d;
  logic [4:0] cnt_q, cnt_d;
  logic plain_q, plain_d;
  logic dir_q, dir_d;
  logic [AW-1:0] k_q, k_d, bi_q, bi_d;
  logic [IDX_W-1:0] n_q, n_d;
  logic [WORD_W-1:0] entry_q, entry_d;
  logic [30:0] m_q, m_d;
  logic [3:0] p_q, p_d;
  logic [15:0] frac_q, frac_d;
  logic [20:0] dv_q, dv_d;
  logic [7:0] rem_q, rem_d;
  logic [30:0] e_q, e_d;
  logic [16:0] f_q, f_d;
  logic [23:0] tmp_q, tmp_d;
  logic [3:0][23:0] acc_q, acc_d;
  logic [CH_W-1:0] ored_q, ored_d, ogrn_q, ogrn_d, oblu_q, oblu_d, otr_q, otr_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic accept, cfg_we, ram_we;
  logic [AW-1:0] fi_c, bi_c, k_next;
  logic [WORD_W-1:0] rdata;
  logic [16:0] t_val;
  logic [3:0] lead_p;
  logic [31:0] sq;
  logic [8:0] trial;
  logic [1:0] ch;
  logic [CH_W-1:0] c_sel;
  logic [30:0] e_shr;
  logic [16:0] aa, y;
  logic [24:0] y255;
  logic [15:0] frac_fin;
  logic [20:0] lval;

  function automatic logic [AW-1:0] clamp_idx(input logic [IDX_W-1:0] v);
    if (32'(v) > TABLE_ENTRIES - 1) begin
      return AW'(TABLE_ENTRIES - 1);
    end
    return AW'(v);
  endfunction

  assign pready = 1'b1;
  assign prdata = {31'd0, mode_q};
  assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
  assign busy = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && !operation_i && (32'(load_index_i) < TABLE_ENTRIES);

  assign fi_c = clamp_idx(front_index_i);
  assign bi_c = clamp_idx(back_index_i);
  assign k_next = dir_q ? k_q + AW'(1) : k_q - AW'(1);

  ptt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(load_index_i)),
    .wdata_i({entry_opacity_i, entry_blue_i, entry_green_i, entry_red_i}),
    .raddr_i(k_q),
    .rdata_o(rdata)
  );

  assign prod = mul_a * mul_b;

  assign t_val = TRANS_TAB[entry_q[31:24]];
  always_comb begin
    lead_p = '0;
    for (int i = 0; i < 16; i++) begin
      if (t_val[i]) begin
        lead_p = 4'(i);
      end
    end
  end

  assign sq = prod[61:30];
  assign frac_fin = sq[31] ? {frac_q[14:0], 1'b1} : {frac_q[14:0], 1'b0};
  assign lval = {1'b0, 4'd0, 16'd0} + ({5'd16 - {1'b0, p_q}, 16'd0}) - {5'd0, frac_fin};
  assign trial = {rem_q, dv_q[20]};
  assign ch = cnt_q[2:1];
  assign e_shr = e_q >> dv_q[20:16];
  assign aa = acc_q[3][16:0];
  assign y = 17'h10000 - aa;
  assign y255 = {y, 8'd0} - {8'd0, y};

  always_comb begin
    case (ch)
      2'd0: c_sel = entry_q[7:0];
      2'd1: c_sel = entry_q[15:8];
      2'd2: c_sel = entry_q[23:16];
      default: c_sel = 8'd1;
    endcase
  end

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    cnt_d = cnt_q;
    plain_d = plain_q;
    dir_d = dir_q;
    k_d = k_q;
    bi_d = bi_q;
    n_d = n_q;
    entry_d = entry_q;
    m_d = m_q;
    p_d = p_q;
    frac_d = frac_q;
    dv_d = dv_q;
    rem_d = rem_q;
    e_d = e_q;
    f_d = f_q;
    tmp_d = tmp_q;
    acc_d = acc_q;
    ored_d = ored_q;
    ogrn_d = ogrn_q;
    oblu_d = oblu_q;
    otr_d = otr_q;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && operation_i) begin
          k_d = fi_c;
          bi_d = bi_c;
          dir_d = fi_c < bi_c;
          n_d = (fi_c > bi_c) ? IDX_W'(fi_c - bi_c) : IDX_W'(bi_c - fi_c);
          plain_d = !mode_q || (fi_c == bi_c);
          acc_d = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_FETCH;
      ST_FETCH: begin
        entry_d = rdata;
        state_d = plain_q ? ST_PLAIN : ST_TCALC;
      end
      ST_PLAIN: begin
        ored_d = div255({8'd0, entry_q[7:0]} * {8'd0, entry_q[31:24]});
        ogrn_d = div255({8'd0, entry_q[15:8]} * {8'd0, entry_q[31:24]});
        oblu_d = div255({8'd0, entry_q[23:16]} * {8'd0, entry_q[31:24]});
        otr_d = 8'd255 - entry_q[31:24];
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_TCALC: begin
        cnt_d = '0;
        if (entry_q[31:24] == 8'd255) begin
          f_d = 17'h10000;
          state_d = ST_BLEND;
        end else if (entry_q[31:24] == 8'd0) begin
          f_d = '0;
          state_d = ST_BLEND;
        end else if (n_q == IDX_W'(1)) begin
          f_d = 17'h10000 - t_val;
          state_d = ST_BLEND;
        end else begin
          m_d = 31'(t_val) << (5'd30 - {1'b0, lead_p});
          p_d = lead_p;
          frac_d = '0;
          state_d = ST_LOG;
        end
      end
      ST_LOG: begin
        // mantissa squaring, one fraction bit of the log per step
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
        m_d = sq[31] ? sq[31:1] : sq[30:0];
        frac_d = frac_fin;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          dv_d = lval;
          rem_d = '0;
          cnt_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divide by the segment length
        if (trial >= {1'b0, n_q}) begin
          rem_d = 8'(trial - {1'b0, n_q});
          dv_d = {dv_q[19:0], 1'b1};
        end else begin
          rem_d = trial[7:0];
          dv_d = {dv_q[19:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd20) begin
          e_d = 31'h4000_0000;
          cnt_d = '0;
          state_d = ST_EXP;
        end
      end
      ST_EXP: begin
        mul_a = {1'b0, e_q};
        mul_b = {1'b0, ROOTS[cnt_q + 5'd1]};
        if (dv_q[4'd15 - cnt_q[3:0]]) begin
          e_d = prod[60:30];
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          cnt_d = '0;
          state_d = ST_CORR;
        end
      end
      ST_CORR: begin
        f_d = 17'h10000 - 17'(e_shr >> 14);
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        // per channel: scale by transmittance, then add colour times opacity
        if (!cnt_q[0]) begin
          mul_a = 32'(acc_q[ch]);
          mul_b = 32'(17'h10000 - f_q);
          tmp_d = prod[39:16];
        end else begin
          mul_a = 32'(c_sel);
          mul_b = 32'(f_q);
          acc_d[ch] = tmp_q + prod[23:0];
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd7) begin
          cnt_d = '0;
          k_d = k_next;
          state_d = (k_next == bi_q) ? ST_FINAL : ST_READ;
        end
      end
      ST_FINAL: begin
        if (aa == 17'd0) begin
          ored_d = '0;
          ogrn_d = '0;
          oblu_d = '0;
          otr_d = 8'd255;
        end else begin
          ored_d = acc_q[0][23:16];
          ogrn_d = acc_q[1][23:16];
          oblu_d = acc_q[2][23:16];
          otr_d = y255[23:16];
        end
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= 1'b0;
      valid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q <= cnt_d;
      if (cfg_we) begin
        mode_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    plain_q <= plain_d;
    dir_q <= dir_d;
    k_q <= k_d;
    bi_q <= bi_d;
    n_q <= n_d;
    entry_q <= entry_d;
    m_q <= m_d;
    p_q <= p_d;
    frac_q <= frac_d;
    dv_q <= dv_d;
    rem_q <= rem_d;
    e_q <= e_d;
    f_q <= f_d;
    tmp_q <= tmp_d;
    acc_q <= acc_d;
    ored_q <= ored_d;
    ogrn_q <= ogrn_d;
    oblu_q <= oblu_d;
    otr_q <= otr_d;
  end

  assign out_valid_o = valid_q;
  assign out_red_o = ored_q;
  assign out_green_o = ogrn_q;
  assign out_blue_o = oblu_q;
  assign out_transparency_o = otr_q;

  `PTT_ASSERT_NXT(a_strobe_single, out_valid_o, !out_valid_o, "result strobe longer than a cycle")
  `PTT_ASSERT_IMP(a_strobe_idle, out_valid_o, !busy, "result while busy")
  `PTT_ASSERT_NXT(a_load_silent, accept && !operation_i, !busy && !out_valid_o,
                  "load beat left the block busy or gave a result")
  `PTT_ASSERT_NXT(a_query_busy, accept && operation_i, busy, "query beat not taken")

endmodule
`default_nettype wire

/* test/tb_preintegrated_transfer_table.sv */
// testbench for the pre-integrated transfer table: table loads, plain and pre-integrated queries
// depends on ptt_pkg and preintegrated_transfer_table; predicts or lists every texel and checks each beat
`default_nettype none
module tb_preintegrated_transfer_table;
  import ptt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 60000;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic MODE_PLAIN = 1'b0;
  localparam logic MODE_PREINT = 1'b1;
  localparam logic [1:0] ADDR_QUALITY_MODE = 2'd0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] transp;
  } texel_t;

  typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic      op;
    logic [7:0] idx, r, g, b, a, fi, bi;
    bit        known;
    texel_t    texel;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic start, busy;
  logic operation_i;
  logic [7:0] load_index_i, entry_red_i, entry_green_i, entry_blue_i, entry_opacity_i;
  logic [7:0] front_index_i, back_index_i;
  logic out_valid_o;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_transparency_o;

  preintegrated_transfer_table DUT (.*);

  logic [31:0] shadow_table [256];
  logic        shadow_mode;
  logic [63:0] exp_roots [17];
  texel_t      texel_q [$];
  int unsigned errors;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // -log2(t/65536) in q5.16
  function automatic int unsigned neg_log2_q16(int unsigned t);
    int unsigned p, frac;
    logic [63:0] m;
    p = 0;
    frac = 0;
    while (p < 15 && (t >> (p + 1)) != 0) p++;
    m = 64'(t) << (30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return ((16 - p) << 16) - frac;
  endfunction

  // opacity corrected for segment length n, q1.16
  function automatic int unsigned seg_opacity(int unsigned alpha, int unsigned n);
    int unsigned t, d, q, rem;
    logic [63:0] e;
    t = ((255 - alpha) * 65536 + 127) / 255;
    e = 64'd1 << 30;
    if (t == 0) return 65536;
    if (t >= 65536) return 0;
    if (n <= 1) return 65536 - t;
    d = neg_log2_q16(t) / n;
    q = d >> 16;
    rem = d & 16'hFFFF;
    for (int i = 1; i <= 16; i++)
      if ((rem >> (16 - i)) & 1) e = (e * exp_roots[i]) >> 30;
    if (q > 40) q = 40;
    return 65536 - int'((e >> q) >> 14);
  endfunction

  function automatic logic [63:0] over(logic [63:0] x, logic [63:0] c, int unsigned f);
    return (x * (65536 - f) + (c << 16) * f) >> 16;
  endfunction

  function automatic texel_t texel_of(logic [7:0] fi, logic [7:0] bi);
    texel_t o;
    logic [31:0] w;
    logic [63:0] rr, gg, bb, aa;
    int unsigned a, n, k, f;
    w = shadow_table[fi];
    if (shadow_mode == MODE_PLAIN || fi == bi) begin
      a = w[31:24];
      o.red = 8'((w[7:0] * a) / 255);
      o.green = 8'((w[15:8] * a) / 255);
      o.blue = 8'((w[23:16] * a) / 255);
      o.transp = 8'(255 - a);
      return o;
    end
    rr = 0; gg = 0; bb = 0; aa = 0;
    n = (fi < bi) ? bi - fi : fi - bi;
    k = fi;
    while (k != bi) begin
      w = shadow_table[k];
      f = seg_opacity(w[31:24], n);
      rr = over(rr, w[7:0], f);
      gg = over(gg, w[15:8], f);
      bb = over(bb, w[23:16], f);
      aa = over(aa, 1, f);
      k = (fi < bi) ? k + 1 : k - 1;
    end
    if (aa > 65536) aa = 65536;
    if (aa == 0) begin
      o = '{8'd0, 8'd0, 8'd0, 8'd255};
    end else begin
      o.red = rr[23:16];
      o.green = gg[23:16];
      o.blue = bb[23:16];
      o.transp = 8'((255 * (65536 - aa)) >> 16);
    end
    return o;
  endfunction

  // drives one item from a falling edge; leaves start high after the beat
  task automatic send_item(logic op, logic [7:0] idx, r, g, b, a, fi, bi,
                           bit known, texel_t texel);
    operation_i = op;
    load_index_i = idx;
    entry_red_i = r;
    entry_green_i = g;
    entry_blue_i = b;
    entry_opacity_i = a;
    front_index_i = fi;
    back_index_i = bi;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    if (op == OP_LOAD) begin
      shadow_table[idx] = {a, b, g, r};
    end else begin
      texel_q.push_back(known ? texel : texel_of(fi, bi));
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    start = 1'b0;
    while (texel_q.size() != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_QUALITY_MODE;
    pwdata = {$urandom} & 32'hFFFF_FFFE | 32'(mode);
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    shadow_mode = mode;
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    texel_t want, got;
    if (rst_ni && out_valid_o) begin
      got = '{out_red_o, out_green_o, out_blue_o, out_transparency_o};
      if (texel_q.size() == 0) begin
        errors++;
        $display("%0t: texel beat with nothing expected, got %h", $time, got);
      end else begin
        want = texel_q.pop_front();
        if (got.red !== want.red) begin
          errors++;
          $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        end
        if (got.green !== want.green) begin
          errors++;
          $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        end
        if (got.blue !== want.blue) begin
          errors++;
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        end
        if (got.transp !== want.transp) begin
          errors++;
          $display("%0t: transparency expected %0d actual %0d", $time, want.transp,
                   got.transp);
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid_o || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("preintegrated_transfer_table verification failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    texel_t none;
    int unsigned burst, gap, n;
    logic [7:0] fi, bi;
    none = '0;
    errors = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; operation_i = OP_LOAD; load_index_i = '0;
    entry_red_i = '0; entry_green_i = '0; entry_blue_i = '0; entry_opacity_i = '0;
    front_index_i = '0; back_index_i = '0;
    shadow_mode = MODE_PLAIN;
    exp_roots[0] = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) exp_roots[i] = root64(exp_roots[i-1] << 30);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // every entry gets written before any query reads it
    for (int i = 0; i < 256; i++)
      send_item(OP_LOAD, 8'(i), 8'($urandom), 8'($urandom), 8'($urandom), pick_alpha(),
                8'($urandom), 8'($urandom), 1'b0, none);

    rows = '{
      '{ROW_MODE, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, none},
      '{ROW_ITEM, OP_LOAD, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 0, 0, 0, none},
      '{ROW_ITEM, OP_LOAD, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0, none},
      '{ROW_ITEM, OP_LOAD, 8'd1, 8'd255, 8'd128, 8'd1, 8'd0, 0, 0, 0, none},
      '{ROW_ITEM, OP_LOAD, 8'd2, 8'd200, 8'd100, 8'd50, 8'd255, 0, 0, 0, none},
      '{ROW_ITEM, OP_LOAD, 8'd3, 8'd10, 8'd20, 8'd30, 8'd128, 0, 0, 0, none},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd0, 8'd255, 1, '{255, 255, 255, 0}},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd255, 8'd0, 1, '{0, 0, 0, 255}},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd1, 8'd1, 1, '{0, 0, 0, 255}},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd2, 8'd7, 1, '{200, 100, 50, 0}},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd3, 8'd3, 0, none},
      '{ROW_MODE, MODE_PREINT, 0, 0, 0, 0, 0, 0, 0, 0, none},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd2, 8'd2, 1, '{200, 100, 50, 0}},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd0, 8'd1, 1, '{255, 255, 255, 0}},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd255, 8'd254, 1, '{0, 0, 0, 255}},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd1, 8'd2, 1, '{0, 0, 0, 255}},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd0, 8'd4, 0, none},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd4, 8'd0, 0, none},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd3, 8'd5, 0, none},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd0, 8'd255, 0, none},
      '{ROW_ITEM, OP_QUERY, 0, 0, 0, 0, 0, 8'd255, 8'd0, 0, none}
    };
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_MODE) begin
        write_mode(rows[i].op);
      end else begin
        send_item(rows[i].op, rows[i].idx, rows[i].r, rows[i].g, rows[i].b, rows[i].a,
                  rows[i].fi, rows[i].bi, rows[i].known, rows[i].texel);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      write_mode((phase % 2 == 0) ? MODE_PREINT : MODE_PLAIN);
      burst = $urandom_range(1, 20);
      for (int it = 0; it < 160; it++) begin
        if ($urandom_range(0, 99) < 40) begin
          send_item(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    pick_alpha(), 8'($urandom), 8'($urandom), 1'b0, none);
        end else begin
          fi = 8'($urandom);
          if (shadow_mode == MODE_PLAIN) begin
            bi = 8'($urandom);
          end else begin
            // mostly short segments, a few long ones
            case ($urandom_range(0, 99)) inside
              [0:84]: n = $urandom_range(0, 6);
              [85:96]: n = $urandom_range(7, 40);
              default: n = $urandom_range(41, 255);
            endcase
            if ($urandom_range(0, 1)) bi = (fi + n > 255) ? 8'd255 : 8'(fi + n);
            else bi = (n > fi) ? 8'd0 : 8'(fi - n);
          end
          send_item(OP_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), fi, bi, 1'b0, none);
        end
        if (--burst == 0) begin
          burst = $urandom_range(1, 20);
          gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk_i);
          end
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("preintegrated_transfer_table verification clean");
    end else begin
      $display("preintegrated_transfer_table verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* preintegrated_transfer_table.f */
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_ram.sv
rtl/preintegrated_transfer_table.sv
test/tb_preintegrated_transfer_table.sv
